### hdl/ajpr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the audio playout resampler.
// No dependencies.
package ajpr_pkg;

  localparam int CFG_W = 18;
  localparam int IDX_W = 3;

  localparam logic [1:0] FUNC_PUSH    = 2'd0;
  localparam logic [1:0] FUNC_TICK    = 2'd1;
  localparam logic [1:0] FUNC_SESSION = 2'd2;

  localparam logic [IDX_W-1:0] REG_STEP   = 3'd0;
  localparam logic [IDX_W-1:0] REG_PRIME  = 3'd1;
  localparam logic [IDX_W-1:0] REG_LOW    = 3'd2;
  localparam logic [IDX_W-1:0] REG_FADE   = 3'd3;
  localparam logic [IDX_W-1:0] REG_VOLUME = 3'd4;
  localparam logic [IDX_W-1:0] REG_CHAN   = 3'd5;

  localparam logic [17:0] STEP_RST   = 18'd65536;
  localparam logic [14:0] PRIME_RST  = 15'd480;
  localparam logic [14:0] LOW_RST    = 15'd60;
  localparam logic [16:0] FADE_RST   = 17'd546;
  localparam logic [15:0] VOLUME_RST = 16'd16384;

  localparam logic [11:0] MID_CODE = 12'd2048;
  localparam logic [11:0] MAX_CODE = 12'd4095;
  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam longint      CLIP_Q30 = 64'd1072668082;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] sample_value;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] dac_word;
    logic        is_mute;
  } out_beat_t;

  function automatic logic [15:0] make_word(logic chan, logic [11:0] code);
    return {chan, 1'b0, 1'b1, 1'b1, code};
  endfunction

endpackage

### hdl/ajpr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module ajpr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### hdl/ajpr_mix.sv
`timescale 1ns / 1ps
// Four-stage interpolate, envelope, volume and code mapping pipeline.
// Depends on ajpr_pkg.
module ajpr_mix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] older_i,
  input  logic signed [15:0] newer_i,
  input  logic [15:0]        frac_i,
  input  logic [16:0]        env_i,
  input  logic [15:0]        volume_i,
  output logic               done_o,
  output logic [11:0]        code_o
);
  import ajpr_pkg::*;

  logic [3:0] vld_q;

  logic signed [33:0] prod_q;
  logic signed [15:0] older_q;
  logic [16:0]        env_q;
  logic signed [35:0] p2_q;
  logic signed [32:0] x_q;
  logic [11:0]        code_q;

  logic signed [16:0] diff;
  logic signed [33:0] rnd;
  logic signed [17:0] interp;
  logic signed [50:0] p2w, t, sct;
  logic signed [15:0] sc;
  logic signed [32:0] xc;
  logic signed [45:0] y, z, cw;
  logic [11:0]        code_d;

  always_comb begin
    diff   = $signed({newer_i[15], newer_i}) - $signed({older_i[15], older_i});
    rnd    = (prod_q + 34'sd32768) >>> 16;
    interp = $signed({{2{older_q[15]}}, older_q}) + rnd[17:0];
    p2w    = $signed({{15{p2_q[35]}}, p2_q});
    t      = (p2w <<< 15) - p2w;
    sct    = (t + 51'sd1073741824) >>> 31;
    if (sct > 51'sd32767) begin
      sc = 16'sh7fff;
    end else if (sct < -51'sd32768) begin
      sc = 16'sh8000;
    end else begin
      sc = sct[15:0];
    end
    if (x_q > 33'(CLIP_Q30)) begin
      xc = 33'(CLIP_Q30);
    end else if (x_q < -$signed(33'(CLIP_Q30))) begin
      xc = -$signed(33'(CLIP_Q30));
    end else begin
      xc = x_q;
    end
    y  = $signed({{13{xc[32]}}, xc}) + 46'sd1073741824;
    z  = (y <<< 12) - y;
    cw = (z + 46'sd1073741824) >>> 31;
    if (cw < 46'sd0) begin
      code_d = 12'd0;
    end else if (cw > 46'sd4095) begin
      code_d = MAX_CODE;
    end else begin
      code_d = cw[11:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= diff * $signed({1'b0, frac_i});
    older_q <= older_i;
    env_q   <= env_i;
    p2_q    <= interp * $signed({1'b0, env_q});
    x_q     <= sc * $signed({1'b0, volume_i});
    if (vld_q[2]) begin
      code_q <= code_d;
    end
  end

  assign done_o = vld_q[3];
  assign code_o = code_q;

endmodule

### hdl/audio_jitter_playout_resampler_core.sv
`timescale 1ns / 1ps
// Playout core: sample FIFO in RAM, resampling sequencer, output register.
// Push and session beats and most muted ticks are handled in IDLE; a playing tick steps
// through POPO and POPN when it primes, then ADV and ADVW per pop, MIX and OUT, one RAM read per pop.
// Reset (async, active low) clears control state and loads register defaults.
// Depends on ajpr_pkg, ajpr_ram, ajpr_mix.
module audio_jitter_playout_resampler_core #(
  parameter int FIFO_DEPTH = 16384
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  ajpr_pkg::in_beat_t          in_beat_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ajpr_pkg::out_beat_t         out_beat_o,
  input  logic                        cfg_we_i,
  input  logic [ajpr_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [ajpr_pkg::CFG_W-1:0]  cfg_data_i
);
  import ajpr_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int FW = AW + 1;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_POPO = 7'b0000010,
    ST_POPN = 7'b0000100,
    ST_ADV  = 7'b0001000,
    ST_ADVW = 7'b0010000,
    ST_MIX  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [FW-1:0] fill_q, fill_d;
  logic signed [15:0] older_q, older_d, newer_q, newer_d;
  logic [18:0] phase_q, phase_d;
  logic [16:0] env_q, env_d;
  logic primed_q, primed_d;
  logic out_valid_q, out_valid_d;
  out_beat_t out_q, out_d, pend_q, pend_d;

  logic [17:0] step_q;
  logic [14:0] prime_q, low_q;
  logic [16:0] fade_q;
  logic [15:0] volume_q;
  logic chan_q;

  logic ram_we, ram_re;
  logic [15:0] ram_rdata;
  logic mix_start, mix_done;
  logic [11:0] mix_code;

  logic in_fire, out_free, lt2, lt_prime, lt_low;
  logic [16:0] env_dn, env_up, env_tick;
  logic [17:0] env_sum;
  logic [AW-1:0] wp_inc, rp_inc;
  out_beat_t mute_beat;

  ajpr_ram #(.WIDTH(16), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wp_q),
    .wdata_i(in_beat_i.sample_value),
    .re_i   (ram_re),
    .raddr_i(rp_q),
    .rdata_o(ram_rdata)
  );

  ajpr_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mix_start),
    .older_i (older_d),
    .newer_i (newer_q),
    .frac_i  (phase_d[15:0]),
    .env_i   (env_tick),
    .volume_i(volume_q),
    .done_o  (mix_done),
    .code_o  (mix_code)
  );

  always_comb begin
    out_free  = !out_valid_q || !out_stall_i;
    in_stall_o = (state_q != ST_IDLE) || !out_free;
    in_fire   = in_valid_i && !in_stall_o;
    lt2       = fill_q < FW'(2);
    lt_prime  = 32'(fill_q) < 32'(prime_q);
    lt_low    = 32'(fill_q) < 32'(low_q);
    env_dn    = (env_q > fade_q) ? env_q - fade_q : 17'd0;
    env_sum   = {1'b0, env_q} + {1'b0, fade_q};
    env_up    = (env_sum > {1'b0, ONE_Q16}) ? ONE_Q16 : env_sum[16:0];
    env_tick  = lt_low ? env_dn : env_up;
    wp_inc    = (32'(wp_q) == FIFO_DEPTH - 1) ? '0 : wp_q + AW'(1);
    rp_inc    = (32'(rp_q) == FIFO_DEPTH - 1) ? '0 : rp_q + AW'(1);
    mute_beat = '{dac_word: make_word(chan_q, MID_CODE), is_mute: 1'b1};

    state_d = state_q; wp_d = wp_q; rp_d = rp_q; fill_d = fill_q;
    older_d = older_q; newer_d = newer_q; phase_d = phase_q; env_d = env_q;
    primed_d = primed_q; out_d = out_q; pend_d = pend_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we = 1'b0; ram_re = 1'b0; mix_start = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_beat_i.func)
            FUNC_PUSH: begin
              if (32'(fill_q) < FIFO_DEPTH) begin
                ram_we = 1'b1;
                wp_d   = wp_inc;
                fill_d = fill_q + FW'(1);
              end
            end
            FUNC_SESSION: begin
              wp_d = '0; rp_d = '0; fill_d = '0;
              older_d = '0; newer_d = '0; phase_d = '0; env_d = '0;
              primed_d = 1'b0;
            end
            FUNC_TICK: begin
              if (!primed_q) begin
                if (lt_prime || lt2) begin
                  out_d = mute_beat; out_valid_d = 1'b1;
                end else begin
                  ram_re = 1'b1; rp_d = rp_inc; fill_d = fill_q - FW'(1);
                  state_d = ST_POPO;
                end
              end else if (lt2) begin
                env_d = env_dn;
                out_d = mute_beat; out_valid_d = 1'b1;
              end else begin
                phase_d = phase_q + 19'(step_q);
                state_d = ST_ADV;
              end
            end
            default: ;
          endcase
        end
      end
      ST_POPO: begin
        older_d = ram_rdata;
        ram_re = 1'b1; rp_d = rp_inc; fill_d = fill_q - FW'(1);
        state_d = ST_POPN;
      end
      ST_POPN: begin
        newer_d  = ram_rdata;
        primed_d = 1'b1;
        if (lt2) begin
          env_d   = env_dn;
          phase_d = '0;
          pend_d  = mute_beat;
          state_d = ST_OUT;
        end else begin
          phase_d = 19'(step_q);
          state_d = ST_ADV;
        end
      end
      ST_ADV: begin
        if (phase_q[18:16] != 3'd0) begin
          older_d = newer_q;
          if (fill_q == '0) begin
            phase_d = {3'd0, phase_q[15:0]};
            env_d = env_tick; mix_start = 1'b1; state_d = ST_MIX;
          end else begin
            ram_re = 1'b1; rp_d = rp_inc; fill_d = fill_q - FW'(1);
            phase_d = phase_q - 19'(ONE_Q16);
            state_d = ST_ADVW;
          end
        end else begin
          env_d = env_tick; mix_start = 1'b1; state_d = ST_MIX;
        end
      end
      ST_ADVW: begin
        newer_d = ram_rdata;
        state_d = ST_ADV;
      end
      ST_MIX: begin
        if (mix_done) begin
          pend_d  = '{dac_word: make_word(chan_q, mix_code), is_mute: 1'b0};
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_d = pend_q; out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; wp_q <= '0; rp_q <= '0; fill_q <= '0;
      older_q <= '0; newer_q <= '0; phase_q <= '0; env_q <= '0;
      primed_q <= 1'b0; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; wp_q <= wp_d; rp_q <= rp_d; fill_q <= fill_d;
      older_q <= older_d; newer_q <= newer_d; phase_q <= phase_d; env_q <= env_d;
      primed_q <= primed_d; out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RST; prime_q <= PRIME_RST; low_q <= LOW_RST;
      fade_q <= FADE_RST; volume_q <= VOLUME_RST; chan_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STEP:   step_q   <= cfg_data_i;
        REG_PRIME:  prime_q  <= cfg_data_i[14:0];
        REG_LOW:    low_q    <= cfg_data_i[14:0];
        REG_FADE:   fade_q   <= cfg_data_i[16:0];
        REG_VOLUME: volume_q <= cfg_data_i[15:0];
        REG_CHAN:   chan_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= FIFO_DEPTH) else $error("fill exceeds depth");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> fill_q != '0) else $error("pop from empty fifo");
  a_unprimed_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !primed_q |-> (phase_q == '0 && env_q == '0)) else $error("unprimed state moved");
  a_mix_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mix_start |=> state_q == ST_MIX) else $error("mix start lost");
`endif

endmodule

### bench/ajpr_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the playout core: mirrors the FIFO, resampler and envelope,
// predicts one DAC word per tick and compares each output beat against it.
// Depends on ajpr_pkg.
module ajpr_checker #(
  parameter int FIFO_DEPTH = 16384
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  ajpr_pkg::in_beat_t         in_beat_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  ajpr_pkg::out_beat_t        out_beat_i,
  input  logic                       cfg_we_i,
  input  logic [ajpr_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [ajpr_pkg::CFG_W-1:0] cfg_data_i,
  output int                         errors_o,
  output int                         pending_o,
  output int                         in_beats_o,
  output int                         words_o,
  output int                         mute_words_o
);
  import ajpr_pkg::*;

  logic signed [15:0] sample_mem [FIFO_DEPTH];
  int          wr_ptr, rd_ptr, fill;
  longint      older, newer;
  longint      ph, env;
  bit          primed;

  longint      step_ratio, prime_level, low_water, fade_step, volume;
  logic        chan_b;

  out_beat_t   word_q[$];

  assign pending_o = word_q.size();

  function automatic longint round_shift(longint v, int k);
    return (v + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic longint pop_sample();
    longint s;
    s = sample_mem[rd_ptr];
    rd_ptr = (rd_ptr + 1 >= FIFO_DEPTH) ? 0 : rd_ptr + 1;
    fill--;
    return s;
  endfunction

  function automatic out_beat_t dac_beat(logic [11:0] code, logic mute);
    out_beat_t b;
    b.dac_word = {chan_b, 1'b0, 1'b1, 1'b1, code};
    b.is_mute  = mute;
    return b;
  endfunction

  function automatic logic [11:0] gain_to_code(longint s16);
    longint x, c;
    x = s16 * volume;
    if (x > CLIP_Q30) x = CLIP_Q30;
    if (x < -CLIP_Q30) x = -CLIP_Q30;
    c = round_shift((x + (longint'(1) <<< 30)) * 4095, 31);
    if (c < 0) c = 0;
    if (c > 4095) c = 4095;
    return c[11:0];
  endfunction

  function automatic void clear_session();
    wr_ptr = 0; rd_ptr = 0; fill = 0;
    older = 0; newer = 0; ph = 0; env = 0; primed = 0;
  endfunction

  function automatic void fade_down();
    env = (env > fade_step) ? env - fade_step : 0;
  endfunction

  function automatic void playout_tick();
    longint interp, scaled;
    if (!primed) begin
      if (fill < prime_level || fill < 2) begin
        word_q.push_back(dac_beat(MID_CODE, 1'b1));
        return;
      end
      older  = pop_sample();
      newer  = pop_sample();
      ph     = 0;
      primed = 1;
    end
    if (fill < 2) begin
      fade_down();
      word_q.push_back(dac_beat(MID_CODE, 1'b1));
      return;
    end
    ph += step_ratio;
    while (ph >= 65536) begin
      older = newer;
      if (fill == 0) begin
        ph &= 65535;
        break;
      end
      newer = pop_sample();
      ph -= 65536;
    end
    interp = older + round_shift((newer - older) * ph, 16);
    if (fill < low_water) fade_down();
    else env = (env + fade_step > 65536) ? 65536 : env + fade_step;
    scaled = round_shift(interp * env * 32767, 31);
    if (scaled > 32767) scaled = 32767;
    if (scaled < -32768) scaled = -32768;
    word_q.push_back(dac_beat(gain_to_code(scaled), 1'b0));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t exp_b;
    if (!rst_ni) begin
      clear_session();
      step_ratio = STEP_RST; prime_level = PRIME_RST; low_water = LOW_RST;
      fade_step = FADE_RST; volume = VOLUME_RST; chan_b = 1'b0;
      word_q.delete();
      errors_o = 0; in_beats_o = 0; words_o = 0; mute_words_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_STEP:   step_ratio  = cfg_data_i[17:0];
          REG_PRIME:  prime_level = cfg_data_i[14:0];
          REG_LOW:    low_water   = cfg_data_i[14:0];
          REG_FADE:   fade_step   = cfg_data_i[16:0];
          REG_VOLUME: volume      = cfg_data_i[15:0];
          REG_CHAN:   chan_b      = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        in_beats_o++;
        case (in_beat_i.func)
          FUNC_PUSH: begin
            if (fill < FIFO_DEPTH) begin
              sample_mem[wr_ptr] = in_beat_i.sample_value;
              wr_ptr = (wr_ptr + 1 >= FIFO_DEPTH) ? 0 : wr_ptr + 1;
              fill++;
            end
          end
          FUNC_TICK:    playout_tick();
          FUNC_SESSION: clear_session();
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        words_o++;
        if (out_beat_i.is_mute) mute_words_o++;
        if (word_q.size() == 0) begin
          $error("unexpected output beat dac_word %h is_mute %b",
                 out_beat_i.dac_word, out_beat_i.is_mute);
          errors_o++;
        end else begin
          exp_b = word_q.pop_front();
          if (out_beat_i.dac_word !== exp_b.dac_word) begin
            $error("dac_word expected %h actual %h", exp_b.dac_word, out_beat_i.dac_word);
            errors_o++;
          end
          if (out_beat_i.is_mute !== exp_b.is_mute) begin
            $error("is_mute expected %b actual %b", exp_b.is_mute, out_beat_i.is_mute);
            errors_o++;
          end
        end
      end
    end
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// Top of the playout core bench: clock, reset, register setup, beat traffic
// with random gaps and stalls, and the verdict. Depends on ajpr_pkg,
// ajpr_checker and the core.
module testbench;
  import ajpr_pkg::*;

  localparam int         DEPTH      = 16384;
  localparam int         LIMIT      = 3000000;
  localparam int         SETTLE     = 24;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  in_beat_t    in_beat_i;
  out_beat_t   out_beat_o;
  logic        cfg_we_i;
  logic [IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  int  errors, pending, in_beats, words, mute_words;
  int  cycles = 0;
  bit  quiet = 1'b0;
  bit  long_hold = 1'b0;
  bit  hold_done = 1'b0;

  always #1 clk_i = ~clk_i;

  audio_jitter_playout_resampler_core #(.FIFO_DEPTH(DEPTH)) dut (.*);

  ajpr_checker #(.FIFO_DEPTH(DEPTH)) u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_beat_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_beat_i(out_beat_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending), .in_beats_o(in_beats),
    .words_o(words), .mute_words_o(mute_words)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // receiver: random stall per beat, one long hold-off on request
  initial begin
    int n;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (2000) @(posedge clk_i);
        hold_done = 1'b1;
      end
      n = quiet ? 0 : $urandom_range(0, 10);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_beat(logic [1:0] func, logic [15:0] sample);
    int n;
    n = quiet ? 0 : $urandom_range(0, 10);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i             <= 1'b1;
    in_beat_i.func         <= func;
    in_beat_i.sample_value <= sample;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic load_regs(int step, int prime, int low, int fade, int vol, int chan);
    int vals [6];
    vals = '{step, prime, low, fade, vol, chan};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= i[IDX_W-1:0];
      cfg_data_i <= vals[i][CFG_W-1:0];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_beat(int tick_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) send_beat(FUNC_SESSION, 16'($urandom));
    else if (r < 4) send_beat(FUNC_SPARE, 16'($urandom));
    else if (r < 4 + tick_pct) send_beat(FUNC_TICK, 16'($urandom));
    else send_beat(FUNC_PUSH, 16'($urandom));
  endtask

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_beat_i  <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= '0;
    cfg_data_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, priming, underrun, spare selector, session
    load_regs(65536, 2, 0, 65536, 65535, 1);
    send_beat(FUNC_TICK, 16'h0000);
    send_beat(FUNC_PUSH, 16'h7FFF);
    send_beat(FUNC_TICK, 16'hFFFF);
    send_beat(FUNC_PUSH, 16'h8000);
    send_beat(FUNC_PUSH, 16'h7FFF);
    send_beat(FUNC_PUSH, 16'h0000);
    send_beat(FUNC_PUSH, 16'hFFFF);
    repeat (5) send_beat(FUNC_TICK, 16'h0000);
    send_beat(FUNC_SPARE, 16'h5A5A);
    send_beat(FUNC_PUSH, 16'h8000);
    send_beat(FUNC_PUSH, 16'h8000);
    send_beat(FUNC_PUSH, 16'h7FFF);
    repeat (3) send_beat(FUNC_TICK, 16'h0000);
    send_beat(FUNC_SESSION, 16'h0000);
    send_beat(FUNC_TICK, 16'h0000);
    settle();

    // fill deep, prime at a high level, skip fast
    load_regs(262143, 300, 300, 1, 0, 0);
    quiet = 1'b1;
    repeat (310) send_beat(FUNC_PUSH, 16'($urandom));
    repeat (4) send_beat(FUNC_TICK, 16'h0000);
    settle();
    load_regs(262143, 300, 0, 65536, 40000, 1);
    repeat (20) send_beat(FUNC_TICK, 16'h0000);
    send_beat(FUNC_SESSION, 16'h0000);
    quiet = 1'b0;
    settle();

    // random phases over varied settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: load_regs(1, 2, 0, 1, 0, 0);
        1: load_regs(262143, 2, 16384, 65536, 65535, 1);
        default:
          load_regs($urandom_range(1, 200000), $urandom_range(2, 40),
                    $urandom_range(0, 30), $urandom_range(1, 65536),
                    $urandom_range(0, 65535), $urandom_range(0, 1));
      endcase
      if (p == 3) long_hold = 1'b1;
      for (int i = 0; i < 216; i++) begin
        if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
        random_beat(p == 3 ? 70 : 44);
      end
      quiet = 1'b0;
      settle();
    end

    $display("covered %0d input beats, %0d DAC words (%0d muted) over 9 register sets",
             in_beats, words, mute_words);
    $display("including deep priming, underrun, sessions and a long output hold");
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

### audio_jitter_playout_resampler_core.f
hdl/ajpr_pkg.sv
hdl/ajpr_ram.sv
hdl/ajpr_mix.sv
hdl/audio_jitter_playout_resampler_core.sv
bench/ajpr_checker.sv
bench/testbench.sv
